// ===== src/json_string_escaper_defines.svh =====
// assertion macros shared by the escaper modules
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// condition in the same cycle
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in the following cycle
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/jse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg
// types, character codes and byte expansion for the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int JSE_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0a;
  localparam logic [7:0] CTL_FF = 8'h0c;
  localparam logic [7:0] CTL_CR = 8'h0d;

  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [3:0] UESC_LEN      = 4'd6;

  typedef enum logic [2:0] {
    K_NONE,
    K_BYTE1,
    K_ESC2,
    K_UESC,
    K_UTF2,
    K_UTF3,
    K_UTF4
  } kind_t;

  typedef struct packed {
    logic        pre_esc;
    logic [9:0]  pre_bits;
    kind_t       kind;
    logic [20:0] data;
    logic        last;
    logic [3:0]  count;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'ha) return CH_ZERO + {4'd0, d};
    else return CH_LOWER_A + {4'd0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] unit_byte(input kind_t k, input logic [20:0] d,
                                           input logic [2:0] j);
    logic [7:0] b;
    b = 8'h00;
    case (k)
      K_BYTE1: b = d[7:0];
      K_ESC2:  b = (j == 3'd0) ? CH_BSLASH : d[7:0];
      K_UESC: begin
        case (j)
          3'd0: b = CH_BSLASH;
          3'd1: b = CH_U;
          3'd2: b = hex_char(d[15:12]);
          3'd3: b = hex_char(d[11:8]);
          3'd4: b = hex_char(d[7:4]);
          default: b = hex_char(d[3:0]);
        endcase
      end
      K_UTF2: b = (j == 3'd0) ? {3'b110, d[10:6]} : {2'b10, d[5:0]};
      K_UTF3: begin
        case (j)
          3'd0: b = {4'b1110, d[15:12]};
          3'd1: b = {2'b10, d[11:6]};
          default: b = {2'b10, d[5:0]};
        endcase
      end
      K_UTF4: begin
        case (j)
          3'd0: b = {5'b11110, d[20:18]};
          3'd1: b = {2'b10, d[17:12]};
          3'd2: b = {2'b10, d[11:6]};
          default: b = {2'b10, d[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/jse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_front
// accepts code units, pairs surrogates and classifies each unit into a job (a held high surrogate gets none)
// ----------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"
module jse_front
  import jse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        q_full,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        full,
  output logic        job_push,
  output job_t        job
);

  logic       held_valid, held_valid_next;
  logic [9:0] held_bits, held_bits_next;
  logic       accept;
  logic       is_high, is_low;
  logic [3:0] unit_count;
  logic [20:0] cp;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign is_high = (code_unit[15:10] == 6'b110110);
  assign is_low  = (code_unit[15:10] == 6'b110111);
  assign cp      = {1'b0, held_bits, code_unit[9:0]} + 21'h10000;

  always_comb begin
    job             = '0;
    job.kind        = K_NONE;
    job.last        = last_unit;
    unit_count      = 4'd0;
    held_valid_next = 1'b0;
    held_bits_next  = 10'd0;
    if (held_valid && is_low) begin
      job.kind   = K_UTF4;
      job.data   = cp;
      unit_count = 4'd4;
    end else begin
      job.pre_esc  = held_valid;
      job.pre_bits = held_bits;
      job.data     = {5'd0, code_unit};
      if (code_unit < 16'h0080) begin
        if (code_unit >= 16'h0020 && code_unit[7:0] != CH_QUOTE &&
            code_unit[7:0] != CH_BSLASH) begin
          job.kind   = K_BYTE1;
          unit_count = 4'd1;
        end else begin
          job.kind   = K_ESC2;
          unit_count = 4'd2;
          case (code_unit[7:0])
            CH_QUOTE:  job.data[7:0] = CH_QUOTE;
            CH_BSLASH: job.data[7:0] = CH_BSLASH;
            CTL_BS:    job.data[7:0] = CH_B;
            CTL_FF:    job.data[7:0] = CH_F;
            CTL_LF:    job.data[7:0] = CH_N;
            CTL_CR:    job.data[7:0] = CH_R;
            CTL_HT:    job.data[7:0] = CH_T;
            default: begin
              job.kind   = K_UESC;
              unit_count = UESC_LEN;
            end
          endcase
        end
      end else if (code_unit < 16'h0800) begin
        job.kind   = K_UTF2;
        unit_count = 4'd2;
      end else if (is_high) begin
        if (last_unit) begin
          job.kind   = K_UESC;
          unit_count = UESC_LEN;
        end else begin
          held_valid_next = 1'b1;
          held_bits_next  = code_unit[9:0];
        end
      end else if (is_low) begin
        job.kind   = K_UESC;
        unit_count = UESC_LEN;
      end else begin
        job.kind   = K_UTF3;
        unit_count = 4'd3;
      end
    end
    job.count = (job.pre_esc ? UESC_LEN : 4'd0) + unit_count;
  end

  assign job_push = accept && (job.count != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_bits  <= 10'd0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      held_bits  <= held_bits_next;
    end
  end

  `JSE_ASSERT_NEXT(a_end_clears_hold, accept && last_unit, !held_valid, "surrogate held past end")

endmodule

// ===== src/jse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue
// short job queue between the classifier and the byte generator
// ----------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"
module jse_queue
  import jse_pkg::*;
#(
  parameter int DEPTH = JSE_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  job_t q_in,
  input  logic q_pop,
  output job_t q_out,
  output logic q_full,
  output logic q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_out   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= q_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  `JSE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count out of range")
  `JSE_ASSERT_NOW(a_no_push_full, q_push, !q_full, "job pushed into a full queue")

endmodule

// ===== src/jse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_back
// expands queued jobs into output bytes, one byte per cycle while the output is popped
// ----------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       q_out,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  job_t       cur;
  logic       cur_valid;
  logic [3:0] idx;
  logic       out_valid;
  logic       emit, is_final, load;
  logic       in_pre;
  logic [2:0] j;
  logic [7:0] byte_sel;

  assign emit     = cur_valid && (!out_valid || pop);
  assign is_final = (idx == cur.count - 4'd1);
  assign load     = !cur_valid || (emit && is_final);
  assign q_pop    = load && !q_empty;
  assign empty    = !out_valid;

  assign in_pre = cur.pre_esc && (idx < UESC_LEN);
  assign j      = cur.pre_esc ? 3'(idx - UESC_LEN) : idx[2:0];

  always_comb begin
    if (in_pre) byte_sel = unit_byte(K_UESC, {5'd0, HIGH_SURR_TAG, cur.pre_bits}, idx[2:0]);
    else byte_sel = unit_byte(cur.kind, cur.data, j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) begin
        cur_valid <= !q_empty;
        idx       <= 4'd0;
      end else if (emit) begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= byte_sel;
      run_last   <= is_final;
      string_end <= is_final && cur.last;
    end
    if (q_pop) cur <= q_out;
  end

  `JSE_ASSERT_NOW(a_idx_range, cur_valid, idx < cur.count, "byte index past job length")
  `JSE_ASSERT_NEXT(a_job_held, emit && !is_final, cur_valid, "job dropped before its last byte")
  `JSE_ASSERT_NOW(a_end_is_run_last, out_valid && string_end, run_last, "string end not on run end")

endmodule

// ===== src/json_string_escaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper
// utf-16 code units in, json-escaped utf-8 bytes out
//
//   channel  dir  handshake     word
//   input    in   push / full   code_unit, last_unit
//   output   out  pop / empty   out_byte, run_last, string_end
//
// one code unit accepted per cycle while the job queue has room
// the byte generator emits one byte per cycle while the output is popped; a unit expands to 1 to 12 bytes there
// a held high surrogate produces no job and costs the back end nothing
// rst is synchronous; it empties the queue, the output register and the surrogate hold
// a stalled pop holds the output byte; the queue then fills and raises full
// ----------------------------------------------------------------------------
module json_string_escaper
  import jse_pkg::*;
#(
  parameter int QUEUE_DEPTH = JSE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        string_end
);

  job_t job_in, job_out;
  logic job_push, job_pop, q_full, q_empty;

  jse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (q_full),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .full      (full),
    .job_push  (job_push),
    .job       (job_in)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (job_push),
    .q_in    (job_in),
    .q_pop   (job_pop),
    .q_out   (job_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_out      (job_out),
    .q_empty    (q_empty),
    .q_pop      (job_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule
